// ===== hw/rtl/pcd_pkg.sv =====
`default_nettype none

package pcd_pkg;

	// sizing of the node table and of the code walk
	localparam int NODE_COUNT    = 512;
	localparam int MAX_CODE_LEN  = 32;
	localparam int BITS_PER_BYTE = 8;

	// fixed field widths
	localparam int SYM_W       = 8;
	localparam int CODE_LEN_W  = 6;
	localparam int CODE_BITS_W = 32;

	// derived widths
	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int FREE_W = $clog2(NODE_COUNT + 1);
	localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
	localparam int BCNT_W = $clog2(BITS_PER_BYTE + 1);

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// one entry of the node table, a child index of zero means no child
	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic [SYM_W-1:0]  sym;
	} node_t;

	localparam int NODE_DATA_W = $bits(node_t);

	// access to the node memory
	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		node_t             wdata;
		logic              re;
		logic [NODE_W-1:0] raddr;
	} ram_req_t;

	// request from the sequencer to the result stage
	typedef struct packed {
		logic             emit;
		logic             flush;
		logic             full;
		logic [SYM_W-1:0] sym;
	} res_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_EV,
		ST_INS_CLR,
		ST_INS_FULL,
		ST_DEC_EV,
		ST_DEC_FIN
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pcd_in_if.sv =====
`default_nettype none

interface pcd_in_if
	import pcd_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic                   cmd;
	logic [SYM_W-1:0]       symbol_in;
	logic [CODE_LEN_W-1:0]  code_length;
	logic [CODE_BITS_W-1:0] code_bits;
	logic [7:0]             data_byte;

	modport source (
		output valid, cmd, symbol_in, code_length, code_bits, data_byte,
		input  ready
	);

	modport sink (
		input  valid, cmd, symbol_in, code_length, code_bits, data_byte,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/pcd_out_if.sv =====
`default_nettype none

interface pcd_out_if
	import pcd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             status;
	logic             last;

	modport source (
		output valid, symbol, status, last,
		input  ready
	);

	modport sink (
		input  valid, symbol, status, last,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/pcd_ram.sv =====
`default_nettype none

module pcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pcd_seq.sv =====
`default_nettype none

module pcd_seq
	import pcd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	pcd_in_if.sink                      items,
	output ram_req_t                    ram_req,
	input  wire logic [NODE_DATA_W-1:0] ram_rdata,
	output res_req_t                    res_req,
	input  wire logic                   res_ready
);

	state_t state_q, state_d;

	logic [NODE_W-1:0]      cur_q;
	logic [FREE_W-1:0]      free_q;
	logic                   root_valid_q;
	logic                   rd_root_q;
	logic                   arrived_q;
	logic                   fresh_q;
	logic [SYM_W-1:0]       sym_q;
	logic [CODE_BITS_W-1:0] code_q;
	logic [7:0]             byte_q;
	logic [LEN_W-1:0]       rem_q;
	logic [BCNT_W-1:0]      bcnt_q;
	logic [NODE_W-1:0]      ins_node_q;

	node_t             rd_node;
	node_t             node_d;
	node_t             ins_wdata;
	logic              leaf;
	logic [NODE_W-1:0] ins_slot;
	logic [NODE_W-1:0] dec_child;
	logic              table_full;
	logic              bits_done;
	logic              accept;

	// root reads as cleared until first written
	assign rd_node = (rd_root_q && !root_valid_q) ? '0 : node_t'(ram_rdata);

	// a freshly allocated node is known to be empty
	assign node_d = fresh_q ? '0 : rd_node;

	assign leaf       = (node_d.left == '0) && (node_d.right == '0);
	assign ins_slot   = code_q[0] ? node_d.right : node_d.left;
	assign dec_child  = byte_q[0] ? node_d.right : node_d.left;
	assign table_full = (free_q == FREE_W'(NODE_COUNT));
	assign bits_done  = (bcnt_q == BCNT_W'(BITS_PER_BYTE));
	assign accept     = items.valid && items.ready;

	// parent entry with the new child linked in
	always_comb begin
		ins_wdata = node_d;
		if (code_q[0]) begin
			ins_wdata.right = free_q[NODE_W-1:0];
		end else begin
			ins_wdata.left = free_q[NODE_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (items.valid) begin
					state_d = (items.cmd == CMD_DECODE) ? ST_DEC_EV : ST_INS_EV;
				end
			end
			ST_INS_EV: begin
				priority if (rem_q == '0) begin
					state_d = ST_IDLE;
				end else if (ins_slot != '0) begin
					state_d = ST_INS_EV;
				end else if (table_full) begin
					state_d = ST_INS_FULL;
				end else begin
					state_d = ST_INS_CLR;
				end
			end
			ST_INS_CLR: begin
				state_d = ST_INS_EV;
			end
			ST_INS_FULL: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_DEC_EV: begin
				if (arrived_q && leaf) begin
					if (node_d.sym == '0) begin
						state_d = ST_DEC_FIN;
					end else if (res_ready && bits_done) begin
						state_d = ST_DEC_FIN;
					end
				end else if (bits_done || dec_child == '0) begin
					state_d = ST_DEC_FIN;
				end
			end
			ST_DEC_FIN: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory, result and handshake outputs
	always_comb begin
		ram_req     = '0;
		res_req     = '0;
		items.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				items.ready   = 1'b1;
				ram_req.re    = items.valid;
				ram_req.raddr = (items.cmd == CMD_DECODE) ? cur_q : '0;
			end
			ST_INS_EV: begin
				priority if (rem_q == '0) begin
					ram_req.we        = 1'b1;
					ram_req.waddr     = ins_node_q;
					ram_req.wdata     = node_d;
					ram_req.wdata.sym = sym_q;
				end else if (ins_slot != '0) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = ins_slot;
				end else if (!table_full) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = ins_node_q;
					ram_req.wdata = ins_wdata;
				end else begin
					ram_req.we = 1'b0;
				end
			end
			ST_INS_CLR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = free_q[NODE_W-1:0];
				ram_req.wdata = '0;
			end
			ST_INS_FULL: begin
				res_req.full = 1'b1;
			end
			ST_DEC_EV: begin
				if (arrived_q && leaf) begin
					if (node_d.sym != '0) begin
						res_req.emit = 1'b1;
						res_req.sym  = node_d.sym;
						if (res_ready && !bits_done) begin
							ram_req.re    = 1'b1;
							ram_req.raddr = '0;
						end
					end
				end else if (!bits_done && dec_child != '0) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = dec_child;
				end
			end
			ST_DEC_FIN: begin
				res_req.flush = 1'b1;
			end
			default: begin
				items.ready = 1'b0;
			end
		endcase
	end

	// state and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			free_q       <= FREE_W'(1);
			root_valid_q <= 1'b0;
			rd_root_q    <= 1'b0;
			arrived_q    <= 1'b0;
			fresh_q      <= 1'b0;
			rem_q        <= '0;
			bcnt_q       <= '0;
			ins_node_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ram_req.re) begin
				rd_root_q <= (ram_req.raddr == '0);
			end
			if (ram_req.we && ram_req.waddr == '0) begin
				root_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rem_q      <= (int'(items.code_length) > MAX_CODE_LEN) ?
							LEN_W'(MAX_CODE_LEN) : LEN_W'(items.code_length);
						bcnt_q     <= '0;
						ins_node_q <= '0;
						arrived_q  <= 1'b0;
						fresh_q    <= 1'b0;
					end
				end
				ST_INS_EV: begin
					if (rem_q != '0 && ins_slot != '0) begin
						ins_node_q <= ins_slot;
						rem_q      <= rem_q - LEN_W'(1);
						fresh_q    <= 1'b0;
					end
				end
				ST_INS_CLR: begin
					ins_node_q <= free_q[NODE_W-1:0];
					free_q     <= free_q + FREE_W'(1);
					rem_q      <= rem_q - LEN_W'(1);
					fresh_q    <= 1'b1;
				end
				ST_DEC_EV: begin
					if (arrived_q && leaf) begin
						if (node_d.sym != '0 && res_ready) begin
							cur_q     <= '0;
							arrived_q <= 1'b0;
						end
					end else if (!bits_done && dec_child != '0) begin
						cur_q     <= dec_child;
						bcnt_q    <= bcnt_q + BCNT_W'(1);
						arrived_q <= 1'b1;
					end
				end
				default: begin
					fresh_q <= fresh_q;
				end
			endcase
		end
	end

	// item payload, shifted as bits are consumed
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= items.symbol_in;
			code_q <= items.code_bits;
			byte_q <= items.data_byte;
		end else begin
			if ((state_q == ST_INS_EV && rem_q != '0 && ins_slot != '0) ||
				state_q == ST_INS_CLR) begin
				code_q <= code_q >> 1;
			end
			if (state_q == ST_DEC_EV && !(arrived_q && leaf) && !bits_done &&
				dec_child != '0) begin
				byte_q <= byte_q >> 1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pcd_out.sv =====
`default_nettype none

module pcd_out
	import pcd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire res_req_t res_req,
	output logic          res_ready,
	pcd_out_if.source     results
);

	logic             out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic             out_status_q;
	logic             out_last_q;
	logic             pend_valid_q;
	logic [SYM_W-1:0] pend_sym_q;

	logic out_free;
	logic load_out;

	assign out_free = !out_valid_q || results.ready;

	// a symbol is held back in a pending register so that the final one can carry last
	always_comb begin
		priority if (res_req.full) begin
			res_ready = out_free;
		end else if (res_req.emit || res_req.flush) begin
			res_ready = !pend_valid_q || out_free;
		end else begin
			res_ready = 1'b0;
		end
	end

	assign load_out = out_free &&
		(res_req.full || ((res_req.emit || res_req.flush) && pend_valid_q));

	// output register and pending symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (res_req.emit && res_ready) begin
				pend_valid_q <= 1'b1;
			end else if (res_req.flush && res_ready) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sym_q    <= res_req.full ? '0 : pend_sym_q;
			out_status_q <= res_req.full ? STATUS_FULL : STATUS_OK;
			out_last_q   <= res_req.full || res_req.flush;
		end
		if (res_req.emit && res_ready) begin
			pend_sym_q <= res_req.sym;
		end
	end

	assign results.valid  = out_valid_q;
	assign results.symbol = out_sym_q;
	assign results.status = out_status_q;
	assign results.last   = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/prefix_code_tree_decoder_core.sv =====
`default_nettype none

// Prefix-code decoder on a node table held in one single-port-write,
// registered-read memory. An insert transaction walks its code bits from the
// root, allocating empty nodes as needed, and stores the symbol at the last
// node; it returns nothing, or one status=1 transaction if the table runs
// out of nodes. A decode transaction consumes one byte LSB first and returns
// zero to eight symbols, with last on the final one. One item is worked on at
// a time. A decode walks at most all eight bits and stops early on a missing
// branch or an end marker; an insert reads each existing node on its path and
// links in and clears each node that it allocates. Stalls on the result side
// can hold both. The pace is set by the node memory: every step of the walk
// waits for the registered read of the node it depends on. The root entry
// reads as empty until first written, so no clearing pass is needed after
// reset.
module prefix_code_tree_decoder_core
	import pcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pcd_in_if.sink    items,
	pcd_out_if.source results
);

	ram_req_t               ram_req;
	logic [NODE_DATA_W-1:0] ram_rdata;
	res_req_t               res_req;
	logic                   res_ready;

	// node table
	pcd_ram #(
		.WIDTH (NODE_DATA_W),
		.DEPTH (NODE_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// tree walk sequencer
	pcd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.res_req   (res_req),
		.res_ready (res_ready)
	);

	// result stage
	pcd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_req   (res_req),
		.res_ready (res_ready),
		.results   (results)
	);

endmodule

`default_nettype wire
